// ===== design/fsnf_pkg.sv =====
// Shared types, character codes and digit tables for the integer formatter.
// Used by fsnf_conv and format_string_number_formatter_top; depends on nothing.
package fsnf_pkg;

  // Argument width and the width of a narrow (non-'l') argument.
  localparam int ARG_W    = 64;
  localparam int NARROW_W = 32;
  // Bit counter width for the serial binary-to-decimal pass (holds ARG_W).
  localparam int BITS_W   = 7;
  localparam int COUNT_W  = 32;

  // Format string character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // Digit to character tables.
  localparam logic [7:0] HEX_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };
  localparam logic [7:0] HEX_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Converter sequencer states.
  typedef enum logic [1:0] {
    CV_IDLE,
    CV_DABBLE,
    CV_STRIP,
    CV_EMIT
  } conv_state_t;

  // Top level control states.
  typedef enum logic {
    T_IDLE,
    T_DIGITS
  } top_state_t;

  // Command from the control to the converter.
  typedef struct packed {
    logic             start;
    logic             hex;
    logic             wide;
    logic [ARG_W-1:0] value;
  } conv_cmd_t;

  // Digit stream from the converter, most significant digit first.
  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
    logic       last;
  } conv_dig_t;

  // Maps one digit to its character in the selected case.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    digit_char = upper ? HEX_UPPER[d] : HEX_LOWER[d];
  endfunction

endpackage

// ===== design/fsnf_conv.sv =====
// Digit-serial number converter: bit-serial binary to BCD (shift and add 3),
// leading zero strip and a digit stream out, most significant first.
// Depends on fsnf_pkg.
module fsnf_conv #(
  parameter int MAX_DIGITS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fsnf_pkg::conv_cmd_t cmd,
  input  logic                dig_take,
  output fsnf_pkg::conv_dig_t dig
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  fsnf_pkg::conv_state_t               state_r, state_nxt;
  logic [fsnf_pkg::ARG_W-1:0]          bin_r, bin_nxt;
  logic [fsnf_pkg::BITS_W-1:0]         bits_r, bits_nxt;
  logic [BCD_W-1:0]                    bcd_r, bcd_nxt;
  logic [BCD_W-1:0]                    bcd_adj;
  logic [CNT_W-1:0]                    ndig_r, ndig_nxt;
  logic [3:0]                          top_digit;

  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // Add 3 to every digit of 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  // State register and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsnf_pkg::CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r  <= bin_nxt;
    bits_r <= bits_nxt;
    bcd_r  <= bcd_nxt;
    ndig_r <= ndig_nxt;
  end

  // Sequencer: load, shift in one bit per cycle, strip zeros, emit digits.
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bits_nxt  = bits_r;
    bcd_nxt   = bcd_r;
    ndig_nxt  = ndig_r;
    unique case (state_r)
      fsnf_pkg::CV_IDLE: begin
        if (cmd.start) begin
          bcd_nxt = '0;
          if (cmd.hex) begin
            bcd_nxt[fsnf_pkg::ARG_W-1:0] = cmd.value;
            ndig_nxt  = CNT_W'(MAX_DIGITS);
            state_nxt = fsnf_pkg::CV_STRIP;
          end else begin
            if (cmd.wide) begin
              bin_nxt  = cmd.value;
              bits_nxt = fsnf_pkg::BITS_W'(fsnf_pkg::ARG_W);
            end else begin
              bin_nxt  = {cmd.value[fsnf_pkg::NARROW_W-1:0],
                          {(fsnf_pkg::ARG_W - fsnf_pkg::NARROW_W){1'b0}}};
              bits_nxt = fsnf_pkg::BITS_W'(fsnf_pkg::NARROW_W);
            end
            state_nxt = fsnf_pkg::CV_DABBLE;
          end
        end
      end
      fsnf_pkg::CV_DABBLE: begin
        bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[fsnf_pkg::ARG_W-1]};
        bin_nxt  = {bin_r[fsnf_pkg::ARG_W-2:0], 1'b0};
        bits_nxt = bits_r - 1'b1;
        if (bits_r == fsnf_pkg::BITS_W'(1)) begin
          ndig_nxt  = CNT_W'(MAX_DIGITS);
          state_nxt = fsnf_pkg::CV_STRIP;
        end
      end
      fsnf_pkg::CV_STRIP: begin
        // Drop one leading zero a cycle, always keeping the last digit.
        if (top_digit == 4'd0 && ndig_r != CNT_W'(1)) begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'h0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          state_nxt = fsnf_pkg::CV_EMIT;
        end
      end
      fsnf_pkg::CV_EMIT: begin
        if (dig_take) begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'h0};
          ndig_nxt = ndig_r - 1'b1;
          if (ndig_r == CNT_W'(1)) begin
            state_nxt = fsnf_pkg::CV_IDLE;
          end
        end
      end
      default: state_nxt = fsnf_pkg::CV_IDLE;
    endcase
  end

  // Digit stream towards the control.
  assign dig.valid = (state_r == fsnf_pkg::CV_EMIT);
  assign dig.digit = top_digit;
  assign dig.last  = (ndig_r == CNT_W'(1));

endmodule

// ===== design/format_string_number_formatter_top.sv =====
// Top level of the integer printf-subset formatter: format byte decode,
// character count, result register. Depends on fsnf_pkg and fsnf_conv.
//
// Channel | Direction | Payload
// in_     | input     | in_fmt_byte[7:0], in_arg_value[63:0]
// out_    | output    | out_char[7:0], out_last_of_run, out_is_end, out_char_count[31:0]
//
// Plain bytes, '%', 'l', unknown conversions and NUL are handled directly in the idle state.
// A decimal conversion runs the bit-serial BCD pass over 32 (narrow) or 64 (wide) bits,
// then strips leading zeros, always keeping the last digit, and then sends its digits.
// A hex conversion skips the BCD pass: it strips leading zeros the same way and sends its digits.
// Reset is synchronous; a stalled out_ready holds the result and pauses digits.
module format_string_number_formatter_top #(
  parameter int MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_fmt_byte,
  input  logic [63:0] in_arg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last_of_run,
  output logic        out_is_end,
  output logic [31:0] out_char_count
);

  fsnf_pkg::top_state_t          state_r, state_nxt;
  logic                          in_conv_r, in_conv_nxt;
  logic                          wide_r, wide_nxt;
  logic                          upper_r, upper_nxt;
  logic [fsnf_pkg::COUNT_W-1:0]  count_r, count_nxt, count_inc;

  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_end_r, out_end_nxt;
  logic [fsnf_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                          out_free;
  logic                          accept;
  logic [fsnf_pkg::ARG_W-1:0]    sval;
  logic [fsnf_pkg::ARG_W-1:0]    mag;
  logic                          neg;

  fsnf_pkg::conv_cmd_t           cmd;
  fsnf_pkg::conv_dig_t           dig;
  logic                          dig_take;

  fsnf_conv #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .dig_take (dig_take),
    .dig      (dig)
  );

  // Handshake and helper values.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == fsnf_pkg::T_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  // Signed argument: narrow values are sign-extended from bit 31.
  assign sval = wide_r ? in_arg_value
                       : {{(fsnf_pkg::ARG_W - fsnf_pkg::NARROW_W){in_arg_value[31]}},
                          in_arg_value[fsnf_pkg::NARROW_W-1:0]};
  assign neg  = sval[fsnf_pkg::ARG_W-1];
  assign mag  = neg ? (fsnf_pkg::ARG_W'(0) - sval) : sval;

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsnf_pkg::T_IDLE;
      in_conv_r   <= 1'b0;
      wide_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_conv_r   <= in_conv_nxt;
      wide_r      <= wide_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    upper_r     <= upper_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_end_r   <= out_end_nxt;
    out_count_r <= out_count_nxt;
  end

  // Format byte decode, digit forwarding and result register loading.
  always_comb begin
    state_nxt     = state_r;
    in_conv_nxt   = in_conv_r;
    wide_nxt      = wide_r;
    upper_nxt     = upper_r;
    count_nxt     = count_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    out_count_nxt = out_count_r;
    cmd.start     = 1'b0;
    cmd.hex       = 1'b0;
    cmd.wide      = wide_r;
    cmd.value     = in_arg_value;
    dig_take      = 1'b0;

    unique case (state_r)
      fsnf_pkg::T_IDLE: begin
        if (accept) begin
          if (in_fmt_byte == fsnf_pkg::CH_NUL) begin
            // End of format: report the total and return to reset state.
            out_valid_nxt = 1'b1;
            out_char_nxt  = fsnf_pkg::CH_NUL;
            out_last_nxt  = 1'b1;
            out_end_nxt   = 1'b1;
            out_count_nxt = count_r;
            count_nxt     = '0;
            in_conv_nxt   = 1'b0;
            wide_nxt      = 1'b0;
          end else if (!in_conv_r) begin
            if (in_fmt_byte == fsnf_pkg::CH_PCT) begin
              in_conv_nxt = 1'b1;
              wide_nxt    = 1'b0;
            end else begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = in_fmt_byte;
              out_last_nxt  = 1'b1;
              out_end_nxt   = 1'b0;
              out_count_nxt = count_inc;
              count_nxt     = count_inc;
            end
          end else if (in_fmt_byte == fsnf_pkg::CH_L) begin
            wide_nxt = 1'b1;
          end else begin
            in_conv_nxt = 1'b0;
            wide_nxt    = 1'b0;
            unique case (in_fmt_byte) inside
              fsnf_pkg::CH_PCT: begin
                out_valid_nxt = 1'b1;
                out_char_nxt  = fsnf_pkg::CH_PCT;
                out_last_nxt  = 1'b1;
                out_end_nxt   = 1'b0;
                out_count_nxt = count_inc;
                count_nxt     = count_inc;
              end
              fsnf_pkg::CH_D, fsnf_pkg::CH_I: begin
                // A negative value sends its minus sign ahead of the digits.
                if (neg) begin
                  out_valid_nxt = 1'b1;
                  out_char_nxt  = fsnf_pkg::CH_MINUS;
                  out_last_nxt  = 1'b0;
                  out_end_nxt   = 1'b0;
                  out_count_nxt = count_inc;
                  count_nxt     = count_inc;
                end
                cmd.start = 1'b1;
                cmd.value = mag;
                upper_nxt = 1'b0;
                state_nxt = fsnf_pkg::T_DIGITS;
              end
              fsnf_pkg::CH_U: begin
                cmd.start = 1'b1;
                upper_nxt = 1'b0;
                state_nxt = fsnf_pkg::T_DIGITS;
              end
              fsnf_pkg::CH_X_LO, fsnf_pkg::CH_X_UP: begin
                cmd.start = 1'b1;
                cmd.hex   = 1'b1;
                if (!wide_r) begin
                  cmd.value = {{(fsnf_pkg::ARG_W - fsnf_pkg::NARROW_W){1'b0}},
                               in_arg_value[fsnf_pkg::NARROW_W-1:0]};
                end
                upper_nxt = (in_fmt_byte == fsnf_pkg::CH_X_UP);
                state_nxt = fsnf_pkg::T_DIGITS;
              end
              default: begin
                // Unknown conversion: nothing is emitted.
              end
            endcase
          end
        end
      end
      fsnf_pkg::T_DIGITS: begin
        // Move one digit into the result register whenever it is free.
        if (dig.valid && out_free) begin
          dig_take      = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = fsnf_pkg::digit_char(dig.digit, upper_r);
          out_last_nxt  = dig.last;
          out_end_nxt   = 1'b0;
          out_count_nxt = count_inc;
          count_nxt     = count_inc;
          if (dig.last) begin
            state_nxt = fsnf_pkg::T_IDLE;
          end
        end
      end
      default: state_nxt = fsnf_pkg::T_IDLE;
    endcase
  end

  // Result channel outputs.
  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;
  assign out_is_end      = out_end_r;
  assign out_char_count  = out_count_r;

endmodule
